// ----- sv/ssp_pkg.sv -----
// Shared types, constants and helper functions for the size string parser.
package ssp_pkg;

    // Default fraction digit cap
    localparam int MAX_FRAC_DIGITS_DEF = 9;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Field widths
    localparam int WHOLE_W = 64;
    localparam int FRAC_W  = 30;
    localparam int DIGS_W  = 4;
    localparam int UNIT_W  = 3;
    localparam int SH_W    = 6;
    localparam int QUO_W   = 50;

    // Character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_K     = 8'h6B;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_T     = 8'h74;

    // Unit exponents (power of 1024)
    localparam logic [UNIT_W-1:0] UNIT_NONE = 3'd0;
    localparam logic [UNIT_W-1:0] UNIT_K    = 3'd1;
    localparam logic [UNIT_W-1:0] UNIT_M    = 3'd2;
    localparam logic [UNIT_W-1:0] UNIT_G    = 3'd3;
    localparam logic [UNIT_W-1:0] UNIT_T    = 3'd4;
    localparam logic [UNIT_W-1:0] UNIT_P    = 3'd5;

    // Parser phase
    typedef enum logic [3:0] {
        PH_LEAD,
        PH_WHOLE,
        PH_DOT,
        PH_FRAC,
        PH_GAP,
        PH_LET,
        PH_UI,
        PH_UDONE,
        PH_TRAIL,
        PH_ERR
    } t_phase;

    // Back end sequencer
    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_DONE
    } t_bstate;

    // One parsed string handed from front to back
    typedef struct packed {
        logic                ok;
        logic [WHOLE_W-1:0]  whole;
        logic [FRAC_W-1:0]   frac;
        logic [DIGS_W-1:0]   digits;
        logic [UNIT_W-1:0]   unit;
    } t_job;

    localparam int JOB_W = $bits(t_job);

    // Queue status toward the two sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // 10^d for d in 0..9
    function automatic logic [FRAC_W-1:0] pow10(input logic [DIGS_W-1:0] d);
        logic [FRAC_W-1:0] v;
        unique case (d)
            4'd0:    v = 30'd1;
            4'd1:    v = 30'd10;
            4'd2:    v = 30'd100;
            4'd3:    v = 30'd1000;
            4'd4:    v = 30'd10000;
            4'd5:    v = 30'd100000;
            4'd6:    v = 30'd1000000;
            4'd7:    v = 30'd10000000;
            4'd8:    v = 30'd100000000;
            4'd9:    v = 30'd1000000000;
            default: v = 30'd1;
        endcase
        return v;
    endfunction

    // Shift amount 10*e for the unit exponent
    function automatic logic [SH_W-1:0] unit_shift(input logic [UNIT_W-1:0] e);
        logic [SH_W-1:0] s;
        unique case (e)
            UNIT_NONE: s = 6'd0;
            UNIT_K:    s = 6'd10;
            UNIT_M:    s = 6'd20;
            UNIT_G:    s = 6'd30;
            UNIT_T:    s = 6'd40;
            default:   s = 6'd50;
        endcase
        return s;
    endfunction

endpackage

// ----- sv/ssp_front.sv -----
// Front end: per-character grammar tracking and digit accumulation.
module ssp_front
    import ssp_pkg::*;
#(
    parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_beat,
    input  logic [7:0] i_ch,
    input  logic       i_last,
    output logic       o_push,
    output t_job       o_job
);

    t_phase              r_phase, n_phase;
    logic [WHOLE_W-1:0]  r_whole, n_whole;
    logic                r_ovf, n_ovf;
    logic [FRAC_W-1:0]   r_frac, n_frac;
    logic [DIGS_W-1:0]   r_digits, n_digits;
    logic [UNIT_W-1:0]   r_unit, n_unit;

    logic                is_ws, is_dig, is_dot;
    logic [7:0]          lc;
    logic [3:0]          dig;
    logic [WHOLE_W+3:0]  whole_x10;
    logic                whole_ovf;
    t_phase              us_phase;
    logic [UNIT_W-1:0]   us_unit;
    logic                accept_end;

    // Character classes
    always_comb begin
        is_ws  = (i_ch == CH_SPACE) || (i_ch == CH_TAB) || (i_ch == CH_CR) || (i_ch == CH_LF);
        is_dig = (i_ch >= CH_0) && (i_ch <= CH_9);
        is_dot = (i_ch == CH_DOT);
        lc     = ((i_ch >= CH_UP_A) && (i_ch <= CH_UP_Z)) ? (i_ch + 8'd32) : i_ch;
        dig    = i_ch[3:0];
    end

    // whole*10 + digit, overflow when the top bits are set
    assign whole_x10 = {1'b0, r_whole, 3'b000} + {3'b000, r_whole, 1'b0}
                     + {{WHOLE_W{1'b0}}, dig};
    assign whole_ovf = |whole_x10[WHOLE_W+3:WHOLE_W];

    // First letter of a unit
    always_comb begin
        us_unit = UNIT_NONE;
        unique case (lc)
            CH_B: begin us_phase = PH_UDONE; us_unit = UNIT_NONE; end
            CH_K: begin us_phase = PH_LET;   us_unit = UNIT_K;    end
            CH_M: begin us_phase = PH_LET;   us_unit = UNIT_M;    end
            CH_G: begin us_phase = PH_LET;   us_unit = UNIT_G;    end
            CH_T: begin us_phase = PH_LET;   us_unit = UNIT_T;    end
            CH_P: begin us_phase = PH_LET;   us_unit = UNIT_P;    end
            default: us_phase = PH_ERR;
        endcase
    end

    // Next phase
    always_comb begin
        unique case (r_phase)
            PH_LEAD: begin
                priority if (is_ws)  n_phase = PH_LEAD;
                else if (is_dig)     n_phase = PH_WHOLE;
                else                 n_phase = PH_ERR;
            end
            PH_WHOLE: begin
                priority if (is_dig) n_phase = PH_WHOLE;
                else if (is_dot)     n_phase = PH_DOT;
                else if (is_ws)      n_phase = PH_GAP;
                else                 n_phase = us_phase;
            end
            PH_DOT: begin
                n_phase = is_dig ? PH_FRAC : PH_ERR;
            end
            PH_FRAC: begin
                priority if (is_dig) n_phase = PH_FRAC;
                else if (is_ws)      n_phase = PH_GAP;
                else                 n_phase = us_phase;
            end
            PH_GAP: begin
                n_phase = is_ws ? PH_GAP : us_phase;
            end
            PH_LET: begin
                priority if (is_ws)                       n_phase = PH_TRAIL;
                else if (lc == CH_I)                      n_phase = PH_UI;
                else if (lc == CH_B && r_unit != UNIT_P)  n_phase = PH_UDONE;
                else                                      n_phase = PH_ERR;
            end
            PH_UI: begin
                n_phase = (lc == CH_B) ? PH_UDONE : PH_ERR;
            end
            PH_UDONE, PH_TRAIL: begin
                n_phase = is_ws ? PH_TRAIL : PH_ERR;
            end
            default: n_phase = PH_ERR;
        endcase
    end

    // Datapath updates
    always_comb begin
        n_whole  = r_whole;
        n_ovf    = r_ovf;
        n_frac   = r_frac;
        n_digits = r_digits;
        n_unit   = r_unit;
        if (is_dig && (r_phase == PH_LEAD || r_phase == PH_WHOLE)) begin
            if (whole_ovf) begin
                n_ovf = 1'b1;
            end else begin
                n_whole = whole_x10[WHOLE_W-1:0];
            end
        end
        if (is_dig && (r_phase == PH_DOT || r_phase == PH_FRAC)
                && (r_digits < DIGS_W'(MAX_FRAC_DIGITS))) begin
            n_frac   = {r_frac[FRAC_W-4:0], 3'b000} + {r_frac[FRAC_W-2:0], 1'b0}
                     + {{(FRAC_W-4){1'b0}}, dig};
            n_digits = r_digits + 4'd1;
        end
        if (!is_dig && !is_ws && !is_dot
                && (r_phase == PH_WHOLE || r_phase == PH_FRAC || r_phase == PH_GAP)) begin
            n_unit = us_unit;
        end
    end

    // String end: accepting phase and no overflow
    assign accept_end = !n_ovf && (n_phase == PH_WHOLE || n_phase == PH_FRAC
                     || n_phase == PH_GAP || n_phase == PH_LET
                     || n_phase == PH_UDONE || n_phase == PH_TRAIL);

    assign o_push       = i_beat && i_last;
    assign o_job.ok     = accept_end;
    assign o_job.whole  = n_whole;
    assign o_job.frac   = n_frac;
    assign o_job.digits = n_digits;
    assign o_job.unit   = n_unit;

    // State registers; a finished string returns everything to its start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_beat && i_last)) begin
            r_phase  <= PH_LEAD;
            r_whole  <= '0;
            r_ovf    <= 1'b0;
            r_frac   <= '0;
            r_digits <= '0;
            r_unit   <= UNIT_NONE;
        end else if (i_beat) begin
            r_phase  <= n_phase;
            r_whole  <= n_whole;
            r_ovf    <= n_ovf;
            r_frac   <= n_frac;
            r_digits <= n_digits;
            r_unit   <= n_unit;
        end
    end

endmodule

// ----- sv/ssp_queue.sv -----
// Small register FIFO carrying parsed jobs from front to back.
module ssp_queue
    import ssp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_job,
    input  logic   i_pop,
    output t_job   o_job,
    output t_qstat o_stat
);

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr, r_rptr;
    logic [QUEUE_AW:0]   r_count;
    logic                do_push, do_pop;

    assign o_stat.full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_job        = r_mem[r_rptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wptr <= r_wptr + 1'b1;
            if (do_pop)  r_rptr <= r_rptr + 1'b1;
            if (do_push && !do_pop)      r_count <= r_count + 1'b1;
            else if (do_pop && !do_push) r_count <= r_count - 1'b1;
        end
    end

endmodule

// ----- sv/ssp_back.sv -----
// Back end: unit scaling, bit-serial fraction division and result register.
module ssp_back
    import ssp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_job         i_job,
    input  t_qstat       i_qstat,
    output logic         o_pop,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [63:0]  o_m_tdata,
    output logic         o_m_tuser
);

    t_bstate             r_state, n_state;
    logic                r_ok;
    logic [WHOLE_W-1:0]  r_whole;
    logic [SH_W-1:0]     r_sh;
    logic [SH_W-1:0]     r_cnt;
    logic [FRAC_W-1:0]   r_rem;
    logic [FRAC_W-1:0]   r_den;
    logic [QUO_W-1:0]    r_q;
    logic                r_mvalid;
    logic                r_muser;
    logic [63:0]         r_mdata;

    logic                out_load;
    logic [FRAC_W:0]     rem2;
    logic                rem_ge;
    logic [WHOLE_W-1:0]  whole_sh;
    logic                sh_ovf;
    logic                fin_ok;

    // Next state
    always_comb begin
        unique case (r_state)
            B_IDLE:  n_state = i_qstat.empty ? B_IDLE : B_DIV;
            B_DIV:   n_state = (r_cnt == '0) ? B_DONE : B_DIV;
            B_DONE:  n_state = (!r_mvalid || i_m_tready) ? B_IDLE : B_DONE;
            default: n_state = B_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_pop    = (r_state == B_IDLE) && !i_qstat.empty;
        out_load = (r_state == B_DONE) && (!r_mvalid || i_m_tready);
    end

    // One quotient bit per cycle: rem = 2*rem, subtract den if it fits
    assign rem2   = {r_rem, 1'b0};
    assign rem_ge = (rem2 >= {1'b0, r_den});

    // Final scaling and range check
    assign whole_sh = r_whole << r_sh;
    assign sh_ovf   = |(r_whole & ~({WHOLE_W{1'b1}} >> r_sh));
    assign fin_ok   = r_ok && !sh_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Job load and division steps
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ok    <= i_job.ok;
            r_whole <= i_job.whole;
            r_sh    <= unit_shift(i_job.unit);
            r_cnt   <= unit_shift(i_job.unit);
            r_rem   <= i_job.frac;
            r_den   <= pow10(i_job.digits);
            r_q     <= '0;
        end else if (r_state == B_DIV && r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
            r_rem <= rem_ge ? FRAC_W'(rem2 - {1'b0, r_den}) : rem2[FRAC_W-1:0];
            r_q   <= {r_q[QUO_W-2:0], rem_ge};
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (out_load) begin
            r_mvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_mvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_muser <= fin_ok;
            r_mdata <= fin_ok ? (whole_sh | {{(WHOLE_W-QUO_W){1'b0}}, r_q}) : '0;
        end
    end

    assign o_m_tvalid = r_mvalid;
    assign o_m_tuser  = r_muser;
    assign o_m_tdata  = r_mdata;

endmodule

// ----- sv/size_string_parser_top.sv -----
// Size string parser top level: character front end, job queue, scaling back end.
// Path: each string's job may wait in the job queue; the back end then forms the
//   fraction bits for unit exponent e (0..5) and may wait on the output handshake.
// Throughput: one character per cycle while the job queue is not full; the back end
//   handles one string at a time, one quotient bit per cycle in its fraction divider.
// Reset: synchronous, active low; clears parser phase, queue and output valid.
module size_string_parser_top
    import ssp_pkg::*;
#(
    parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] ch
    input  logic        i_s_tlast,   // last character of the string
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [63:0] byte_count
    output logic        o_m_tuser    // [0] valid_res
);

    logic   s_beat;
    logic   push;
    logic   pop;
    t_job   front_job;
    t_job   queue_job;
    t_qstat qstat;

    assign o_s_tready = !qstat.full;
    assign s_beat     = i_s_tvalid && o_s_tready;

    ssp_front #(
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (s_beat),
        .i_ch    (i_s_tdata),
        .i_last  (i_s_tlast),
        .o_push  (push),
        .o_job   (front_job)
    );

    ssp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_stat  (qstat)
    );

    ssp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (queue_job),
        .i_qstat    (qstat),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // A string end never arrives while the queue is full
    assert property (@(posedge i_clk) disable iff (!i_rst_n) push |-> !qstat.full)
        else $error("job pushed into full queue");

    // The back end only takes jobs that are there
    assert property (@(posedge i_clk) disable iff (!i_rst_n) pop |-> !qstat.empty)
        else $error("job popped from empty queue");

    // A rejected string reports a zero byte count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == 64'd0))
        else $error("rejected result with nonzero byte count");

    // No result right after reset
    assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule
